[rtl/asfs_pkg.sv]
package asfs_pkg;

    // Register indexes on the configuration channel
    localparam logic [2:0] REG_BIT_PERIOD     = 3'd0;
    localparam logic [2:0] REG_DATA_BITS      = 3'd1;
    localparam logic [2:0] REG_STOP_BITS      = 3'd2;
    localparam logic [2:0] REG_PREAMBLE_BITS  = 3'd3;
    localparam logic [2:0] REG_POSTAMBLE_BITS = 3'd4;

    // Reset values of the registers
    localparam logic [15:0] RST_BIT_PERIOD     = 16'd128;
    localparam logic [3:0]  RST_DATA_BITS      = 4'd8;
    localparam logic [1:0]  RST_STOP_BITS      = 2'd2;
    localparam logic [4:0]  RST_PREAMBLE_BITS  = 5'd20;
    localparam logic [4:0]  RST_POSTAMBLE_BITS = 5'd10;

    // Saturation limits
    localparam logic [3:0] MAX_DATA  = 4'd8;
    localparam logic [1:0] MAX_STOP  = 2'd2;
    localparam logic [4:0] MAX_AMBLE = 5'd24;

    // Characters and levels
    localparam logic [7:0] ESC_CHAR    = 8'h5C;
    localparam logic [7:0] CHAR_R      = 8'h72;
    localparam logic [7:0] CHAR_N      = 8'h6E;
    localparam logic [7:0] CR_CHAR     = 8'd13;
    localparam logic [7:0] LF_CHAR     = 8'd10;
    localparam logic [7:0] MARK_LEVEL  = 8'hFF;
    localparam logic [7:0] SPACE_LEVEL = 8'h00;

    // One classified request passed from front to back
    typedef struct packed {
        logic       first;
        logic       last;
        logic       send;
        logic [7:0] byte_val;
    } t_cmd;

    // Live configuration seen by the back end
    typedef struct packed {
        logic [15:0] bit_period;
        logic [3:0]  data_bits;
        logic [1:0]  stop_bits;
        logic [4:0]  preamble_bits;
        logic [4:0]  postamble_bits;
    } t_cfg;

endpackage

[rtl/async_serial_frame_serializer_core.sv]
// Channel   | Dir | Handshake                   | Payload
// ----------+-----+-----------------------------+----------------------------------------
// s (input) | in  | i_s_tvalid / o_s_tready     | tdata=character, tuser=first, tlast=last
// m (out)   | out | o_m_tvalid / i_m_tready     | tdata=level,hold; tlast=last_of_run
// cfg       | in  | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// Flow: the front takes one request per cycle while the queue has room; the back
// pops a request only once the previous one has emitted its last bit, then emits its
// preamble, start, data, stop and postamble bits in order, each part only where present.
// Reset: synchronous, active low; clears escape state, queue, sequencer, registers.
// Stalls: a low i_m_tready holds the output register and freezes the sequencer;
// the queue keeps absorbing requests until it is full.
module async_serial_frame_serializer_core
    import asfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] character
    input  logic        i_s_tuser,   // [0] first_of_message
    input  logic        i_s_tlast,   // last_of_message
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] sample_level, [23:8] hold_samples
    output logic        o_m_tlast,   // last_of_run
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic s_accept;

    // Configuration writes are always accepted and registered; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_period     <= RST_BIT_PERIOD;
            r_cfg.data_bits      <= RST_DATA_BITS;
            r_cfg.stop_bits      <= RST_STOP_BITS;
            r_cfg.preamble_bits  <= RST_PREAMBLE_BITS;
            r_cfg.postamble_bits <= RST_POSTAMBLE_BITS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_BIT_PERIOD:     r_cfg.bit_period     <= i_cfg_data;
                REG_DATA_BITS:      r_cfg.data_bits      <= i_cfg_data[3:0];
                REG_STOP_BITS:      r_cfg.stop_bits      <= i_cfg_data[1:0];
                REG_PREAMBLE_BITS:  r_cfg.preamble_bits  <= i_cfg_data[4:0];
                REG_POSTAMBLE_BITS: r_cfg.postamble_bits <= i_cfg_data[4:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    // Accept a request whenever the queue has a free slot
    assign o_s_tready = !q_full;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Front: escape handling and classification
    asfs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (s_accept),
        .i_character (i_s_tdata),
        .i_first     (i_s_tuser),
        .i_last      (i_s_tlast),
        .o_cmd       (front_cmd)
    );

    // Decouple front from back
    asfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (s_accept),
        .i_push_data (front_cmd),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (queue_cmd),
        .o_empty     (q_empty)
    );

    // Back: bit sequencer with output register
    asfs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_empty    (q_empty),
        .i_cmd      (queue_cmd),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

[rtl/asfs_front.sv]
module asfs_front
    import asfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_character,
    input  logic       i_first,
    input  logic       i_last,
    output t_cmd       o_cmd
);

    logic r_esc;
    logic n_esc;
    logic esc_in;

    // Resolve escapes for the request on the input
    always_comb begin
        esc_in         = i_first ? 1'b0 : r_esc;
        n_esc          = esc_in;
        o_cmd.first    = i_first;
        o_cmd.last     = i_last;
        o_cmd.send     = 1'b0;
        o_cmd.byte_val = i_character;
        if (i_character == ESC_CHAR) begin
            n_esc = 1'b1;
        end else if (esc_in) begin
            n_esc = 1'b0;
            if (i_character == CHAR_R) begin
                o_cmd.send     = 1'b1;
                o_cmd.byte_val = CR_CHAR;
            end else if (i_character == CHAR_N) begin
                o_cmd.send     = 1'b1;
                o_cmd.byte_val = LF_CHAR;
            end
        end else begin
            o_cmd.send = 1'b1;
        end
        if (i_last) begin
            n_esc = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
        end else if (i_accept) begin
            r_esc <= n_esc;
        end
    end

endmodule

[rtl/asfs_queue.sv]
module asfs_queue
    import asfs_pkg::*;
#(
    parameter int DEPTH = 2
)(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_pop_data,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full     = (r_count == FULL_CNT);
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/asfs_back.sv]
module asfs_back
    import asfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_empty,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,
    output logic        o_m_tlast
);

    logic        r_busy;
    logic [5:0]  r_pos;
    logic [5:0]  r_total;
    logic [4:0]  r_pre;
    logic [3:0]  r_nd;
    logic        r_send;
    logic [7:0]  r_byte;
    logic        r_ov;
    logic [7:0]  r_level;
    logic [15:0] r_hold;
    logic        r_last;

    logic [3:0]  nd_sat;
    logic [1:0]  ns_sat;
    logic [4:0]  pre_sat;
    logic [4:0]  post_sat;
    logic [4:0]  pre_n;
    logic [5:0]  frame_n;
    logic [5:0]  total_n;
    logic [6:0]  rel;
    logic [2:0]  data_idx;
    logic        is_start;
    logic        is_data;
    logic        space;
    logic        emit;
    logic        bit_last;
    logic [15:0] hold_n;

    // Saturate the live settings and work out the request's bit count and the bit hold
    always_comb begin
        nd_sat   = (i_cfg.data_bits > MAX_DATA) ? MAX_DATA : i_cfg.data_bits;
        ns_sat   = (i_cfg.stop_bits > MAX_STOP) ? MAX_STOP : i_cfg.stop_bits;
        pre_sat  = (i_cfg.preamble_bits > MAX_AMBLE) ? MAX_AMBLE : i_cfg.preamble_bits;
        post_sat = (i_cfg.postamble_bits > MAX_AMBLE) ? MAX_AMBLE : i_cfg.postamble_bits;
        pre_n    = i_cmd.first ? pre_sat : 5'd0;
        frame_n  = i_cmd.send ? (6'd1 + {2'b00, nd_sat} + {4'b0000, ns_sat}) : 6'd0;
        total_n  = {1'b0, pre_n} + frame_n + (i_cmd.last ? {1'b0, post_sat} : 6'd0);
        hold_n   = (i_cfg.bit_period == 16'd0) ? 16'd1 : i_cfg.bit_period;
    end

    // Level of the bit at r_pos
    always_comb begin
        rel      = {1'b0, r_pos} - {2'b00, r_pre};
        data_idx = 3'(rel - 7'd1);
        is_start = r_send && (r_pos == {1'b0, r_pre});
        is_data  = r_send && (r_pos > {1'b0, r_pre}) && (rel <= {3'b000, r_nd});
        space    = is_start || (is_data && !r_byte[data_idx]);
        bit_last = (r_pos == r_total - 6'd1);
    end

    assign o_pop = !r_busy && !i_empty;
    assign emit  = r_busy && (!r_ov || i_m_tready);

    // Load a request and register each emitted bit; drop a request when it makes no bits
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pre   <= pre_n;
            r_nd    <= nd_sat;
            r_send  <= i_cmd.send;
            r_byte  <= i_cmd.byte_val;
            r_total <= total_n;
        end
        if (emit) begin
            r_level <= space ? SPACE_LEVEL : MARK_LEVEL;
            r_hold  <= hold_n;
            r_last  <= bit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= (total_n != 6'd0);
                r_pos  <= '0;
            end else if (emit) begin
                r_pos <= r_pos + 6'd1;
                if (bit_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {r_hold, r_level};
    assign o_m_tlast  = r_last;

endmodule

[rtl/asfs_check.sv]
module asfs_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tlast
);

    // Hold a stalled result
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output valid dropped under stall");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output payload changed under stall");

    // Levels are only space or mark
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[7:0] == 8'h00 || o_m_tdata[7:0] == 8'hFF))
        else $error("sample level neither space nor mark");

    // A bit is always held for at least one sample
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[23:8] != 16'd0))
        else $error("zero hold count");

endmodule

bind async_serial_frame_serializer_core asfs_check u_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
